// File: sv/bba_pkg.sv
package bba_pkg;

	// register reset values and default buffer limits
	localparam int WIDTH_RESET    = 1024;
	localparam int HEIGHT_RESET   = 1024;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	// field widths
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_W  = 13;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;

	// window sum: up to nine 8-bit values, count 1 to 9
	localparam int SUM_W  = 12;
	localparam int CNT_W  = 4;

	// rounding mean by reciprocal multiply
	localparam int RECIP_SH = 24;
	localparam int RECIP_W  = 24;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_PIXEL = 1'b0,
		KIND_FLUSH = 1'b1
	} kind_t;

	// red in the lowest byte
	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	// one line buffer entry: row above and current middle row
	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
	} line_word_t;

	// per item control handed from the input side to the window stage
	typedef struct packed {
		logic flush;
		logic has_a;
		logic has_b;
		logic top_ok;
		logic bot_ok;
		logic left_a;
		logic left_b;
		logic right;
		logic last;
	} item_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
		logic [CNT_W-1:0] count;
		logic             last;
	} sum_t;

	// ceil(2^24 / (2*n)) for n = 1..9
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			4'd1:    m = 24'd8388608;
			4'd2:    m = 24'd4194304;
			4'd3:    m = 24'd2796203;
			4'd4:    m = 24'd2097152;
			4'd5:    m = 24'd1677722;
			4'd6:    m = 24'd1398102;
			4'd7:    m = 24'd1198373;
			4'd8:    m = 24'd1048576;
			4'd9:    m = 24'd932068;
			default: m = 24'd8388608;
		endcase
		return m;
	endfunction

endpackage

// File: sv/bba_line_ram.sv
module bba_line_ram #(
	parameter int DEPTH = bba_pkg::MAX_WIDTH_DEF,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bba_pkg::line_word_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr_a,
	input  logic [AW-1:0]       rd_addr_b,
	output bba_pkg::line_word_t rd_data_a,
	output bba_pkg::line_word_t rd_data_b
);

	bba_pkg::line_word_t mem_q [DEPTH];
	bba_pkg::line_word_t rd_a_q;
	bba_pkg::line_word_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// a write on the same edge is forwarded to the read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr_a) begin
				rd_a_q <= wr_data;
			end else begin
				rd_a_q <= mem_q[rd_addr_a];
			end
			if (wr_en && wr_addr == rd_addr_b) begin
				rd_b_q <= wr_data;
			end else begin
				rd_b_q <= mem_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// File: sv/bba_window.sv
module bba_window #(
	parameter int CW = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	output logic                ready,
	input  bba_pkg::item_ctl_t  ctl_in,
	input  logic [CW-1:0]       col_in,
	input  bba_pkg::rgb_t       px_in,
	input  bba_pkg::line_word_t rd_a,
	input  bba_pkg::line_word_t rd_b,
	output logic                wr_en,
	output logic [CW-1:0]       wr_addr,
	output bba_pkg::line_word_t wr_data,
	output logic                sum_valid,
	output bba_pkg::sum_t       sum_out,
	input  logic                sum_ready
);

	localparam int SW  = bba_pkg::SUM_W;
	localparam int CNW = bba_pkg::CNT_W;

	logic                valid_s1;
	bba_pkg::item_ctl_t  ctl_s1;
	logic [CW-1:0]       col_s1;
	bba_pkg::rgb_t       px_s1;
	logic                sel_q;
	bba_pkg::line_word_t prev_q;
	bba_pkg::rgb_t [8:0] win_q;

	bba_pkg::rgb_t [8:0] win_new;
	bba_pkg::rgb_t [8:0] win_fl;
	bba_pkg::rgb_t [8:0] cur_win;
	logic [2:0]          row_en;
	logic [2:0]          col_en;
	logic                cur_b;
	logic                emit_any;
	logic                emit;
	logic                done;
	logic                leave;
	logic                s2_ready;
	bba_pkg::sum_t       sum_c;

	logic                valid_s2;
	bba_pkg::sum_t       sum_s2;

	// result order: left neighbor of the column first, row end column second
	assign emit_any = ctl_s1.has_a || ctl_s1.has_b;
	assign emit     = valid_s1 && emit_any;
	assign done     = sel_q || !(ctl_s1.has_a && ctl_s1.has_b);
	assign s2_ready = !valid_s2 || sum_ready;
	assign leave    = valid_s1 && (!emit_any || (s2_ready && done));
	assign ready    = !valid_s1 || leave;
	assign cur_b    = sel_q || !ctl_s1.has_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sel_q    <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (leave) begin
				valid_s1 <= 1'b0;
			end
			if (leave) begin
				sel_q <= 1'b0;
			end else if (emit && s2_ready) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s1 <= ctl_in;
			col_s1 <= col_in;
			px_s1  <= px_in;
			prev_q <= rd_a;
		end
		if (leave && !ctl_s1.flush) begin
			win_q <= win_new;
		end
	end

	always_comb begin
		win_new[0] = win_q[1];
		win_new[1] = win_q[2];
		win_new[2] = rd_a.upper;
		win_new[3] = win_q[4];
		win_new[4] = win_q[5];
		win_new[5] = rd_a.middle;
		win_new[6] = win_q[7];
		win_new[7] = win_q[8];
		win_new[8] = px_s1;

		// drain: three columns of the two stored rows, bottom row unused
		win_fl[0] = prev_q.upper;
		win_fl[1] = rd_a.upper;
		win_fl[2] = rd_b.upper;
		win_fl[3] = prev_q.middle;
		win_fl[4] = rd_a.middle;
		win_fl[5] = rd_b.middle;
		win_fl[6] = px_s1;
		win_fl[7] = px_s1;
		win_fl[8] = px_s1;

		cur_win = ctl_s1.flush ? win_fl : win_new;
	end

	assign row_en = {ctl_s1.bot_ok, 1'b1, ctl_s1.top_ok};
	assign col_en = {cur_b ? 1'b1 : ctl_s1.right,
			cur_b ? ctl_s1.left_b : 1'b1,
			!cur_b && ctl_s1.left_a};

	always_comb begin
		sum_c = '0;
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if (row_en[rr] && col_en[cc]) begin
					sum_c.red   = sum_c.red + SW'(cur_win[rr*3+cc].red);
					sum_c.green = sum_c.green + SW'(cur_win[rr*3+cc].green);
					sum_c.blue  = sum_c.blue + SW'(cur_win[rr*3+cc].blue);
					sum_c.count = sum_c.count + CNW'(1);
				end
			end
		end
		sum_c.last = ctl_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && emit) begin
			sum_s2 <= sum_c;
		end
	end

	assign sum_valid = valid_s2;
	assign sum_out   = sum_s2;

	// upper gets the old middle row, middle gets the new pixel
	assign wr_en          = leave && !ctl_s1.flush;
	assign wr_addr        = col_s1;
	assign wr_data.upper  = rd_a.middle;
	assign wr_data.middle = px_s1;

	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> valid_s1 && ctl_s1.has_a && ctl_s1.has_b)
		else $error("second result pending on an item with one result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> sum_s2.count != '0 && sum_s2.count <= CNW'(9))
		else $error("window count out of range");

	a_flush_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> valid_s1 && !ctl_s1.flush && !$past(wr_en && !load))
		else $error("line buffer write from a drain item or repeated write");

endmodule

// File: sv/bba_mean.sv
module bba_mean (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  bba_pkg::sum_t in_sum,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bba_pkg::rgb_t out_pixel,
	output logic          out_last
);

	localparam int XW = bba_pkg::SUM_W + 1;
	localparam int MW = bba_pkg::RECIP_W;
	localparam int PW = XW + MW;
	localparam int SH = bba_pkg::RECIP_SH;
	localparam int CH = bba_pkg::CH_W;

	logic          valid_q;
	bba_pkg::rgb_t pix_q;
	logic          last_q;

	logic [MW-1:0] m;
	logic [XW-1:0] x_r, x_g, x_b;
	logic [PW-1:0] p_r, p_g, p_b;
	bba_pkg::rgb_t q;

	assign in_ready = !valid_q || out_ready;

	// floor((2*sum + n) / (2*n)) as a reciprocal multiply
	assign m   = bba_pkg::recip(in_sum.count);
	assign x_r = {in_sum.red, 1'b0} + XW'(in_sum.count);
	assign x_g = {in_sum.green, 1'b0} + XW'(in_sum.count);
	assign x_b = {in_sum.blue, 1'b0} + XW'(in_sum.count);
	assign p_r = PW'(x_r) * PW'(m);
	assign p_g = PW'(x_g) * PW'(m);
	assign p_b = PW'(x_b) * PW'(m);
	assign q.red   = p_r[SH +: CH];
	assign q.green = p_g[SH +: CH];
	assign q.blue  = p_b[SH +: CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pix_q  <= q;
			last_q <= in_sum.last;
		end
	end

	assign out_valid = valid_q;
	assign out_pixel = pix_q;
	assign out_last  = last_q;

endmodule

// File: sv/box_blur_3x3_edge_aware_top.sv
// 3x3 box blur with edge-aware averaging over an rgb frame in raster order.
// input channel s_*: s_tuser is the item kind (0 pixel, 1 flush), s_tdata
// carries red, green, blue from the lowest byte up. pixels of the frame come
// first, then one flush item per column drains the last row.
// output channel m_*: one blurred pixel per frame pixel, same byte order; m_tlast
// marks the final pixel of the frame. each output is the rounded-half-up mean
// of the neighbors that lie inside the frame (9, 6, 4 or fewer).
// output lags input by one row: the pixel at column c of row r releases the
// result for column c-1 of row r-1, and the last column of a row releases a
// second one for the row end.
// throughput: one item per clock unless the output stalls; a row-end pixel
// from the second row on, in a frame wider than one column, holds the window
// stage until its second result is taken. the results of an item pass the
// window stage register, the sum register and the mean output register.
// both line buffers sit in one 48-bit memory read on two ports with registered
// outputs and written back by the window stage, with same-column forwarding.
// cfg_we with cfg_index 0/1 writes frame width/height and restarts the frame.
// reset restarts the frame at 1024x1024; line buffers are not cleared and are
// never used before being written in a frame. a low m_tready holds the output
// register; with three results waiting s_tready drops until it frees.
module box_blur_3x3_edge_aware_top #(
	parameter int MAX_WIDTH  = bba_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bba_pkg::MAX_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [bba_pkg::PIX_W-1:0] s_tdata,  // red_in, green_in, blue_in
	input  logic                      s_tuser,  // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [bba_pkg::PIX_W-1:0] m_tdata,  // red_out, green_out, blue_out
	output logic                      m_tlast,  // frame_end
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data
);

	localparam int FW   = bba_pkg::FW_W;
	localparam int FH   = bba_pkg::FH_W;
	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WX   = $clog2(MAX_WIDTH + 1);
	localparam int HX   = $clog2(MAX_HEIGHT + 1);
	localparam int WE_W = (FW > WX) ? FW : WX;
	localparam int HE_W = (FH > HX) ? FH : HX;
	localparam int RST_W = (bba_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
			: bba_pkg::WIDTH_RESET;
	localparam int RST_H = (bba_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
			: bba_pkg::HEIGHT_RESET;

	// frame position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] flush_q;
	logic          drain_q;
	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;

	// clamped register values
	logic [WE_W-1:0] w_eff;
	logic [HE_W-1:0] h_eff;
	logic [CW-1:0]   new_last_col;
	logic [RW-1:0]   new_last_row;

	logic               accept;
	logic               is_flush;
	logic               take_px;
	logic               take_fl;
	logic               load;
	bba_pkg::item_ctl_t ctl;
	logic [CW-1:0]      rd_addr_a;
	logic [CW-1:0]      rd_addr_b;

	bba_pkg::line_word_t rd_a;
	bba_pkg::line_word_t rd_b;
	logic                wr_en;
	logic [CW-1:0]       wr_addr;
	bba_pkg::line_word_t wr_data;

	logic          sum_valid;
	bba_pkg::sum_t sum_out;
	logic          sum_ready;
	bba_pkg::rgb_t out_pixel;

	// zero acts as one, anything above the buffer size as the buffer size
	always_comb begin
		if (cfg_data[FW-1:0] == '0) begin
			w_eff = WE_W'(1);
		end else if (WE_W'(cfg_data[FW-1:0]) > WE_W'(MAX_WIDTH)) begin
			w_eff = WE_W'(MAX_WIDTH);
		end else begin
			w_eff = WE_W'(cfg_data[FW-1:0]);
		end
		if (cfg_data[FH-1:0] == '0) begin
			h_eff = HE_W'(1);
		end else if (HE_W'(cfg_data[FH-1:0]) > HE_W'(MAX_HEIGHT)) begin
			h_eff = HE_W'(MAX_HEIGHT);
		end else begin
			h_eff = HE_W'(cfg_data[FH-1:0]);
		end
		new_last_col = CW'(w_eff - WE_W'(1));
		new_last_row = RW'(h_eff - HE_W'(1));
	end

	// pixels outside the pixel phase and flushes outside the drain are dropped
	assign accept   = s_tvalid && s_tready;
	assign is_flush = (s_tuser == bba_pkg::KIND_FLUSH);
	assign take_px  = accept && !is_flush && !drain_q;
	assign take_fl  = accept && is_flush && drain_q;
	assign load     = take_px || take_fl;

	// pixel reads its own column; drain reads the column and the next one
	assign rd_addr_a = drain_q ? flush_q : col_q;
	assign rd_addr_b = flush_q + CW'(1);

	always_comb begin
		if (drain_q) begin
			ctl.flush  = 1'b1;
			ctl.has_a  = 1'b1;
			ctl.has_b  = 1'b0;
			ctl.top_ok = (last_row_q != '0);
			ctl.bot_ok = 1'b0;
			ctl.left_a = (flush_q != '0);
			ctl.left_b = 1'b0;
			ctl.right  = (flush_q != last_col_q);
			ctl.last   = (flush_q == last_col_q);
		end else begin
			ctl.flush  = 1'b0;
			ctl.has_a  = (row_q != '0) && (col_q != '0);
			ctl.has_b  = (row_q != '0) && (col_q == last_col_q);
			ctl.top_ok = (row_q > RW'(1));
			ctl.bot_ok = 1'b1;
			ctl.left_a = (col_q > CW'(1));
			ctl.left_b = (col_q != '0);
			ctl.right  = 1'b1;
			ctl.last   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			flush_q    <= '0;
			drain_q    <= 1'b0;
			last_col_q <= CW'(RST_W - 1);
			last_row_q <= RW'(RST_H - 1);
		end else if (cfg_we) begin
			// any register write restarts the frame
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= '0;
			drain_q <= 1'b0;
			unique case (cfg_index)
				bba_pkg::REG_FRAME_WIDTH: begin
					last_col_q <= new_last_col;
				end
				bba_pkg::REG_FRAME_HEIGHT: begin
					last_row_q <= new_last_row;
				end
			endcase
		end else if (take_px) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				if (row_q == last_row_q) begin
					row_q   <= '0;
					flush_q <= '0;
					drain_q <= 1'b1;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (take_fl) begin
			if (flush_q == last_col_q) begin
				flush_q <= '0;
				drain_q <= 1'b0;
			end else begin
				flush_q <= flush_q + CW'(1);
			end
		end
	end

	bba_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (load),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	bba_window #(
		.CW (CW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ready     (s_tready),
		.ctl_in    (ctl),
		.col_in    (col_q),
		.px_in     (bba_pkg::rgb_t'(s_tdata)),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.sum_valid (sum_valid),
		.sum_out   (sum_out),
		.sum_ready (sum_ready)
	);

	bba_mean u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_sum    (sum_out),
		.in_ready  (sum_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pixel (out_pixel),
		.out_last  (m_tlast)
	);

	assign m_tdata = out_pixel;

	a_drain_pos: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> col_q == '0 && row_q == '0)
		else $error("frame position not cleared during drain");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q && flush_q <= last_col_q && row_q <= last_row_q)
		else $error("frame position beyond the configured frame");

	a_end_of_drain: assert property (@(posedge clk) disable iff (!arst_n)
		take_fl && flush_q == last_col_q && !cfg_we |=> !drain_q && flush_q == '0)
		else $error("drain did not end after the last column");

endmodule
